@@ rtl/twc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_pkg
// shared types and default widths for the twitch waveform characterizer
// ----------------------------------------------------------------------------
package twc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF   = 32;

  typedef enum logic [1:0] {
    PH_WAIT_PEAK = 2'd0,
    PH_WAIT_HALF = 2'd1,
    PH_DONE      = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   primed;
    logic   in_stimulus;
  } twc_status_t;

endpackage

@@ rtl/twc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_if
// sample and result channels, valid/ready with payload
// ----------------------------------------------------------------------------
interface twc_sample_if #(
  parameter int SW = 16,
  parameter int TW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] stim_sample;
  logic signed [SW-1:0] length_sample;
  logic signed [SW-1:0] velocity_sample;
  logic        [TW-1:0] timestamp;

  modport source (output valid, stim_sample, length_sample, velocity_sample, timestamp,
                  input ready);
  modport sink   (input valid, stim_sample, length_sample, velocity_sample, timestamp,
                  output ready);
endinterface

interface twc_result_if #(
  parameter int SW = 16,
  parameter int TW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] baseline_length;
  logic signed [SW-1:0] contraction_length;
  logic signed [SW:0]   twitch_amplitude;
  logic        [TW-1:0] time_to_peak;
  logic        [TW-1:0] half_relax_time;

  modport source (output valid, baseline_length, contraction_length, twitch_amplitude,
                  time_to_peak, half_relax_time, input ready);
  modport sink   (input valid, baseline_length, contraction_length, twitch_amplitude,
                  time_to_peak, half_relax_time, output ready);
endinterface

@@ rtl/twitch_waveform_characterizer.sv @@
`timescale 1ns / 1ps
// path: a sample transaction is registered in the input register, then the tracker result
// in the result register, and a stall on the result channel can hold it in either
// throughput: one transaction per cycle while results.ready is high, with the tracker
// update between the input register and the result register
// reset: synchronous rst clears all twitch measures, the phase and the primed flag;
// the first sample after reset stands in as its own previous sample
// ----------------------------------------------------------------------------
// twitch_waveform_characterizer
// measures baseline, contraction, amplitude, time to peak and half relaxation
// ----------------------------------------------------------------------------
module twitch_waveform_characterizer
  import twc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int TIME_WIDTH   = TIME_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  twc_sample_if.sink   samples,
  twc_result_if.source results
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int TW = TIME_WIDTH;

  logic                 s1_valid;
  logic                 s1_fire;
  logic signed [SW-1:0] s1_stim;
  logic signed [SW-1:0] s1_len;
  logic signed [SW-1:0] s1_vel;
  logic        [TW-1:0] s1_time;

  logic                 out_valid;
  logic signed [SW-1:0] out_baseline;
  logic signed [SW-1:0] out_contraction;
  logic signed [SW:0]   out_amplitude;
  logic        [TW-1:0] out_peak_delay;
  logic        [TW-1:0] out_relax_delay;

  logic signed [SW-1:0] baseline_next;
  logic signed [SW-1:0] contraction_next;
  logic signed [SW:0]   amplitude_next;
  logic        [TW-1:0] peak_delay_next;
  logic        [TW-1:0] relax_delay_next;
  twc_status_t          status;

  logic in_take;

  assign s1_fire       = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || s1_fire;
  assign in_take       = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !s1_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_stim <= samples.stim_sample;
      s1_len  <= samples.length_sample;
      s1_vel  <= samples.velocity_sample;
      s1_time <= samples.timestamp;
    end
  end

  twc_track #(
    .SW (SW),
    .TW (TW)
  ) u_track (
    .clk              (clk),
    .rst              (rst),
    .update           (s1_fire),
    .stim             (s1_stim),
    .len              (s1_len),
    .vel              (s1_vel),
    .now              (s1_time),
    .baseline_next    (baseline_next),
    .contraction_next (contraction_next),
    .amplitude_next   (amplitude_next),
    .peak_delay_next  (peak_delay_next),
    .relax_delay_next (relax_delay_next),
    .status           (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_fire || (out_valid && !results.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_baseline    <= baseline_next;
      out_contraction <= contraction_next;
      out_amplitude   <= amplitude_next;
      out_peak_delay  <= peak_delay_next;
      out_relax_delay <= relax_delay_next;
    end
  end

  assign results.valid              = out_valid;
  assign results.baseline_length    = out_baseline;
  assign results.contraction_length = out_contraction;
  assign results.twitch_amplitude   = out_amplitude;
  assign results.time_to_peak       = out_peak_delay;
  assign results.half_relax_time    = out_relax_delay;

`ifndef SYNTH
  // a staged sample always produces a result in the next cycle
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("staged sample did not reach the result register");

  // a new transaction never overwrites a staged sample that has not moved on
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_take && s1_valid) |-> s1_fire)
    else $error("staged sample overwritten");

  // leaving the peak search needs at least one processed sample
  a_phase_primed: assert property (@(posedge clk) disable iff (rst)
    (status.phase != PH_WAIT_PEAK) |-> status.primed)
    else $error("phase advanced before any sample");

  // stimulus tracking also implies a processed sample
  a_stim_primed: assert property (@(posedge clk) disable iff (rst)
    status.in_stimulus |-> status.primed)
    else $error("stimulus flag set before any sample");
`endif

endmodule

@@ rtl/twc_track.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_track
// twitch state tracker: onset, peak and half relaxation rules for one tick
// ----------------------------------------------------------------------------
module twc_track
  import twc_pkg::*;
#(
  parameter int SW = SAMPLE_WIDTH_DEF,
  parameter int TW = TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 update,
  input  logic signed [SW-1:0] stim,
  input  logic signed [SW-1:0] len,
  input  logic signed [SW-1:0] vel,
  input  logic        [TW-1:0] now,
  output logic signed [SW-1:0] baseline_next,
  output logic signed [SW-1:0] contraction_next,
  output logic signed [SW:0]   amplitude_next,
  output logic        [TW-1:0] peak_delay_next,
  output logic        [TW-1:0] relax_delay_next,
  output twc_status_t          status
);

  logic signed [SW-1:0] prev_length;
  logic signed [SW-1:0] prev_velocity;
  logic                 primed;
  logic                 in_stimulus;
  phase_t               phase;
  phase_t               phase_next;
  logic signed [SW-1:0] baseline;
  logic signed [SW-1:0] contraction;
  logic signed [SW:0]   amplitude;
  logic        [TW-1:0] onset_time;
  logic        [TW-1:0] peak_time;
  logic        [TW-1:0] peak_delay;
  logic        [TW-1:0] relax_delay;

  logic signed [SW-1:0] pl;
  logic signed [SW-1:0] pv;
  logic                 onset;
  logic                 peak;
  logic                 half;
  phase_t               phase_onset;
  phase_t               phase_peak;
  logic        [TW-1:0] onset_time_next;
  logic        [TW-1:0] peak_time_next;
  logic signed [SW+1:0] len_x2;
  logic signed [SW+1:0] mid_sum;

  // rule evaluation
  always_comb begin
    pl = primed ? prev_length : len;
    pv = primed ? prev_velocity : vel;

    onset           = stim[SW-1] && !in_stimulus;
    phase_onset     = onset ? PH_WAIT_PEAK : phase;
    baseline_next   = onset ? pl : baseline;
    onset_time_next = onset ? now : onset_time;

    // zero velocity, or positive velocity reached from a non-positive one
    peak = (vel >= $signed({SW{1'b0}})) &&
           ((vel == $signed({SW{1'b0}})) || (pv <= $signed({SW{1'b0}}))) &&
           (phase_onset == PH_WAIT_PEAK);
    phase_peak       = peak ? PH_WAIT_HALF : phase_onset;
    contraction_next = peak ? len : contraction;
    amplitude_next   = peak ? ($signed({baseline_next[SW-1], baseline_next}) -
                               $signed({len[SW-1], len})) : amplitude;
    peak_time_next   = peak ? now : peak_time;
    peak_delay_next  = peak ? (now - onset_time_next) : peak_delay;

    // halfway test without halving: 2*len >= contraction + baseline
    len_x2  = {len[SW-1], len, 1'b0};
    mid_sum = $signed({{2{contraction_next[SW-1]}}, contraction_next}) +
              $signed({{2{baseline_next[SW-1]}}, baseline_next});
    half    = (phase_peak == PH_WAIT_HALF) && (len_x2 >= mid_sum);
    relax_delay_next = half ? (now - peak_time_next) : relax_delay;
  end

  // phase next state
  always_comb begin
    if (half) begin
      phase_next = PH_DONE;
    end else begin
      phase_next = phase_peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_length   <= '0;
      prev_velocity <= '0;
      primed        <= 1'b0;
      in_stimulus   <= 1'b0;
      phase         <= PH_WAIT_PEAK;
      baseline      <= '0;
      contraction   <= '0;
      amplitude     <= '0;
      onset_time    <= '0;
      peak_time     <= '0;
      peak_delay    <= '0;
      relax_delay   <= '0;
    end else if (update) begin
      prev_length   <= len;
      prev_velocity <= vel;
      primed        <= 1'b1;
      in_stimulus   <= stim[SW-1];
      phase         <= phase_next;
      baseline      <= baseline_next;
      contraction   <= contraction_next;
      amplitude     <= amplitude_next;
      onset_time    <= onset_time_next;
      peak_time     <= peak_time_next;
      peak_delay    <= peak_delay_next;
      relax_delay   <= relax_delay_next;
    end
  end

  always_comb begin
    status.phase       = phase;
    status.primed      = primed;
    status.in_stimulus = in_stimulus;
  end

endmodule

@@ bench/twitch_waveform_characterizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twitch_waveform_characterizer_tb
// drives sample transactions through the characterizer and checks every result
// transaction against a cycle-free twitch tracker: a directed table first, then
// random twitch sequences with noise, under four idling and stalling mixes
// ----------------------------------------------------------------------------
module twitch_waveform_characterizer_tb;
  import twc_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int TW = TIME_WIDTH_DEF;
  localparam int CLK_PERIOD = 10;
  localparam int SMAX = 2 ** (SW - 1) - 1;
  localparam int SMIN = -(2 ** (SW - 1));
  localparam int RANDOM_PER_PHASE = 435;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic signed [SW-1:0] stim;
    logic signed [SW-1:0] len;
    logic signed [SW-1:0] vel;
    logic        [TW-1:0] ts;
  } twitch_sample_t;

  typedef struct {
    logic signed [SW-1:0] baseline;
    logic signed [SW-1:0] contraction;
    logic signed [SW:0]   amplitude;
    logic        [TW-1:0] peak_delay;
    logic        [TW-1:0] relax_delay;
  } twitch_meas_t;

  typedef struct {
    int          stim;
    int          len;
    int          vel;
    logic [31:0] ts;
    bit          has_meas;
    int          baseline;
    int          contraction;
    int          amplitude;
    logic [31:0] peak_delay;
    logic [31:0] relax_delay;
  } dir_row_t;

  // stim, length, velocity, timestamp, then the measures where they are obvious
  dir_row_t dir_rows [20] = '{
    '{0, 100, 0, 32'd10, 1, 0, 100, -100, 32'd10, 32'd0},
    '{-1, 32767, -5, 32'd20, 0, 0, 0, 0, 32'd0, 32'd0},
    '{-32768, -32768, -100, 32'd25, 0, 0, 0, 0, 32'd0, 32'd0},
    '{0, -32768, 32767, 32'd30, 0, 0, 0, 0, 32'd0, 32'd0},
    '{32767, 32767, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 32'd0, 32'd0},
    '{0, 32767, -32768, 32'd40, 0, 0, 0, 0, 32'd0, 32'd0},
    '{-2, -32768, -32768, 32'hFFFF_FFF0, 0, 0, 0, 0, 32'd0, 32'd0},
    '{0, -32768, 1, 32'd5, 0, 0, 0, 0, 32'd0, 32'd0},
    '{0, 0, 5, 32'd6, 0, 0, 0, 0, 32'd0, 32'd0},
    '{0, -32768, -3, 32'd7, 0, 0, 0, 0, 32'd0, 32'd0},
    '{-300, 32767, -3, 32'd8, 0, 0, 0, 0, 32'd0, 32'd0},
    '{-300, 32767, 0, 32'd9, 0, 0, 0, 0, 32'd0, 32'd0},
    '{0, 0, -1, 32'd12, 0, 0, 0, 0, 32'd0, 32'd0},
    '{32767, 512, 0, 32'd13, 0, 0, 0, 0, 32'd0, 32'd0},
    '{-1, 256, -1, 32'd100, 0, 0, 0, 0, 32'd0, 32'd0},
    '{0, 128, -1, 32'd101, 0, 0, 0, 0, 32'd0, 32'd0},
    '{0, 128, 1, 32'd102, 0, 0, 0, 0, 32'd0, 32'd0},
    '{0, 319, 2, 32'd105, 0, 0, 0, 0, 32'd0, 32'd0},
    '{0, 320, 2, 32'd110, 0, 0, 0, 0, 32'd0, 32'd0},
    '{0, 320, 0, 32'd111, 0, 0, 0, 0, 32'd0, 32'd0}
  };

  int idle_by_phase  [4] = '{0, 87, 0, 33};
  int stall_by_phase [4] = '{0, 0, 87, 33};

  logic clk = 1'b0;
  logic rst;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  logic [TW-1:0] ts_now = 32'hFFFF_FC00;
  twitch_meas_t meas_due [$];

  // tracker state, reset values
  logic signed [SW-1:0] trk_prev_len = '0;
  logic signed [SW-1:0] trk_prev_vel = '0;
  logic                 trk_primed = 1'b0;
  logic                 trk_in_stim = 1'b0;
  phase_t               trk_phase = PH_WAIT_PEAK;
  logic signed [SW-1:0] trk_baseline = '0;
  logic signed [SW-1:0] trk_contraction = '0;
  logic signed [SW:0]   trk_amplitude = '0;
  logic        [TW-1:0] trk_onset = '0;
  logic        [TW-1:0] trk_peak = '0;
  logic        [TW-1:0] trk_peak_delay = '0;
  logic        [TW-1:0] trk_relax_delay = '0;

  twc_sample_if #(.SW(SW), .TW(TW)) smp ();
  twc_result_if #(.SW(SW), .TW(TW)) res ();

  twitch_waveform_characterizer #(
    .SAMPLE_WIDTH(SW),
    .TIME_WIDTH  (TW)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .samples(smp),
    .results(res)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic twitch_meas_t track_twitch(input twitch_sample_t s);
    twitch_meas_t m;
    logic crossing;
    if (!trk_primed) begin
      trk_prev_len = s.len;
      trk_prev_vel = s.vel;
      trk_primed = 1'b1;
    end
    if (s.stim < 0) begin
      // only the first tick of a negative run counts as onset
      if (!trk_in_stim) begin
        trk_phase = PH_WAIT_PEAK;
        trk_baseline = trk_prev_len;
        trk_onset = s.ts;
      end
      trk_in_stim = 1'b1;
    end else begin
      trk_in_stim = 1'b0;
    end
    crossing = (s.vel <= 0 && trk_prev_vel >= 0) || (s.vel >= 0 && trk_prev_vel <= 0);
    if (crossing && trk_phase == PH_WAIT_PEAK && s.vel >= 0) begin
      trk_contraction = s.len;
      trk_amplitude = (SW + 1)'(int'(trk_baseline) - int'(trk_contraction));
      trk_peak = s.ts;
      trk_peak_delay = s.ts - trk_onset;
      trk_phase = PH_WAIT_HALF;
    end
    // halfway test with the length doubled
    if (trk_phase == PH_WAIT_HALF &&
        2 * int'(s.len) >= int'(trk_contraction) + int'(trk_baseline)) begin
      trk_relax_delay = s.ts - trk_peak;
      trk_phase = PH_DONE;
    end
    trk_prev_len = s.len;
    trk_prev_vel = s.vel;
    m.baseline = trk_baseline;
    m.contraction = trk_contraction;
    m.amplitude = trk_amplitude;
    m.peak_delay = trk_peak_delay;
    m.relax_delay = trk_relax_delay;
    return m;
  endfunction

  function automatic int clamp_sample(input int v);
    return (v > SMAX) ? SMAX : (v < SMIN) ? SMIN : v;
  endfunction

  function automatic int rand_sample();
    return int'($signed(SW'($urandom)));
  endfunction

  function automatic twitch_sample_t next_sample(input int stim, input int len, input int vel);
    twitch_sample_t s;
    s.stim = SW'(clamp_sample(stim));
    s.len = SW'(clamp_sample(len));
    s.vel = SW'(clamp_sample(vel));
    s.ts = ts_now;
    ts_now = ($urandom_range(0, 49) == 0) ? TW'($urandom) : ts_now + 1'b1;
    return s;
  endfunction

  // called just after a rising edge; returns at the edge that accepts the transaction
  task automatic send_sample(input twitch_sample_t s);
    while ($urandom_range(0, 99) < idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.stim_sample <= s.stim;
    smp.length_sample <= s.len;
    smp.velocity_sample <= s.vel;
    smp.timestamp <= s.ts;
    do @(posedge clk); while (!smp.ready);
    meas_due.push_back(track_twitch(s));
    items_sent++;
  endtask

  // rest, stimulus with shortening, shortening after it, peak, then recovery with the odd stray onset
  task automatic send_twitch();
    int base;
    int len;
    int n;
    base = ($urandom_range(0, 7) == 0) ? rand_sample() : int'($urandom_range(0, 12000)) - 2000;
    len = base;
    n = $urandom_range(1, 3);
    repeat (n) begin
      send_sample(next_sample(int'($urandom_range(0, SMAX)),
                              base + int'($urandom_range(0, 40)) - 20,
                              int'($urandom_range(0, 200)) - 100));
    end
    n = $urandom_range(1, 4);
    repeat (n) begin
      len -= int'($urandom_range(0, 1500));
      send_sample(next_sample(-int'($urandom_range(1, 32768)), len,
                              -int'($urandom_range(1, 3000))));
    end
    n = $urandom_range(0, 5);
    repeat (n) begin
      len -= int'($urandom_range(0, 1500));
      send_sample(next_sample(int'($urandom_range(0, SMAX)), len,
                              -int'($urandom_range(1, 3000))));
    end
    send_sample(next_sample(int'($urandom_range(0, SMAX)), len,
                            ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 500))));
    n = $urandom_range(1, 8);
    repeat (n) begin
      len += int'($urandom_range(0, 2500));
      send_sample(next_sample(($urandom_range(0, 7) == 0) ? -int'($urandom_range(1, 32768))
                                                          : int'($urandom_range(0, SMAX)),
                              len, int'($urandom_range(0, 3000)) - 200));
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    twitch_meas_t want;
    if (!rst && res.valid && res.ready) begin
      if (meas_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result transaction with nothing expected", $time);
      end else begin
        want = meas_due.pop_front();
        check_field("baseline_length", 32'(want.baseline), 32'(res.baseline_length));
        check_field("contraction_length", 32'(want.contraction), 32'(res.contraction_length));
        check_field("twitch_amplitude", 32'(want.amplitude), 32'(res.twitch_amplitude));
        check_field("time_to_peak", want.peak_delay, res.time_to_peak);
        check_field("half_relax_time", want.relax_delay, res.half_relax_time);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL twitch_waveform_characterizer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    twitch_sample_t s;
    twitch_meas_t m;
    int target;
    rst <= 1'b1;
    smp.valid <= 1'b0;
    smp.stim_sample <= '0;
    smp.length_sample <= '0;
    smp.velocity_sample <= '0;
    smp.timestamp <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      s.stim = SW'(dir_rows[i].stim);
      s.len = SW'(dir_rows[i].len);
      s.vel = SW'(dir_rows[i].vel);
      s.ts = dir_rows[i].ts;
      send_sample(s);
      if (dir_rows[i].has_meas) begin
        m.baseline = SW'(dir_rows[i].baseline);
        m.contraction = SW'(dir_rows[i].contraction);
        m.amplitude = (SW + 1)'(dir_rows[i].amplitude);
        m.peak_delay = dir_rows[i].peak_delay;
        m.relax_delay = dir_rows[i].relax_delay;
        meas_due[meas_due.size() - 1] = m;
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      // hold off until every outstanding result has drained
      smp.valid <= 1'b0;
      while (meas_due.size() != 0) @(posedge clk);
      idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      target = items_sent + RANDOM_PER_PHASE;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 15)
          send_sample(next_sample(rand_sample(), rand_sample(), rand_sample()));
        else
          send_twitch();
      end
    end

    smp.valid <= 1'b0;
    while (meas_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS twitch_waveform_characterizer");
    else
      $display("FAIL twitch_waveform_characterizer");
    $finish;
  end

endmodule
